FILE: hw/rtl/mbp_pkg.sv
// shared types and constants of the msb-first bit packer
`default_nettype none

package mbp_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned FieldWidthW = 6;
  localparam int unsigned TotalW     = 20;

  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned FieldCapInt  = (MaxFieldBits < 32) ? MaxFieldBits : 32;
  localparam logic [FieldWidthW-1:0] FieldCap = FieldWidthW'(FieldCapInt);

  localparam logic [TotalW-1:0] CounterMax = '1;
  localparam logic [6:0]        SeptetMask = 7'h7F;
  localparam int unsigned       SeptetBits = 7;

  typedef enum logic [1:0] {
    ActWriteBits = 2'd0,
    ActWriteVarint = 2'd1,
    ActFlush = 2'd2,
    ActClear = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [ValueW-1:0]      value;
    logic [FieldWidthW-1:0] field_width;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              last;
    logic [TotalW-1:0] bits_total;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbp_in_if.sv
// input channel of the bit packer
`default_nettype none

interface mbp_in_if
  import mbp_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [ValueW-1:0]      value;
  logic [FieldWidthW-1:0] field_width;

  modport source (output valid, output action, output value, output field_width,
                  input ready);
  modport sink   (input valid, input action, input value, input field_width,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mbp_out_if.sv
// result channel of the bit packer
`default_nettype none

interface mbp_out_if
  import mbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              byte_valid;
  logic              last;
  logic [TotalW-1:0] bits_total;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output bits_total, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input bits_total, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/msb_first_bit_packer.sv
// top level of the msb-first bit packer with varint writes
//
//   channel | dir | beat                                   | accepted when
//   in_i    | in  | action, value, field_width             | valid && ready
//   out_o   | out | out_byte, byte_valid, last, bits_total | valid && ready
//
// flush and clear are answered from the idle state. write bits and write varint
// (a varint is 1 to 5 bytes) run the shifter, which moves one 8-bit digit per
// cycle while the output stage has room. reset zeroes the pending bits and the bit counter.
// a stalled result holds in the output register; the shifter waits on it.
`default_nettype none

module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mbp_in_if.sink     in_i,
  mbp_out_if.source  out_o
);

  in_beat_t in_beat;
  logic     in_ready;
  logic     out_rdy;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign in_beat.action      = in_i.action;
  assign in_beat.value       = in_i.value;
  assign in_beat.field_width = in_i.field_width;
  assign in_i.ready          = in_ready;

  mbp_digit_shifter u_shifter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_beat),
    .in_ready_o  (in_ready),
    .out_rdy_i   (out_rdy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mbp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_rdy_o   (out_rdy),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.out_byte   = out_res.out_byte;
  assign out_o.byte_valid = out_res.byte_valid;
  assign out_o.last       = out_res.last;
  assign out_o.bits_total = out_res.bits_total;

endmodule

`default_nettype wire

FILE: hw/rtl/mbp_digit_shifter.sv
// byte-digit shift datapath: appends fields and cuts completed bytes
`default_nettype none

module mbp_digit_shifter
  import mbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_beat_t in_beat_i,
  output logic          in_ready_o,
  input  wire logic     out_rdy_i,
  output logic          res_valid_o,
  output res_t          res_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [6:0]        pend_q, pend_d;
  logic [2:0]        pcnt_q, pcnt_d;
  logic [TotalW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0] src_q, src_d;
  logic [5:0]        rem_q, rem_d;
  logic [2:0]        left_q, left_d;
  logic              varint_q, varint_d;

  logic [FieldWidthW-1:0] width_sat;
  logic [2:0]             nbytes;
  logic [5:0]             added;
  logic [TotalW:0]        cnt_sum;
  logic [6:0]             tot_bits;
  logic [7:0]             fl_byte;

  logic        step;
  logic [3:0]  k;
  logic        more;
  logic [7:0]  digit;
  logic [14:0] acc;
  logic [3:0]  n_next;
  logic        emit;
  logic        run_end;

  assign in_ready_o = (state_q == StIdle) && out_rdy_i;
  assign step       = (state_q == StRun) && out_rdy_i;

  always_comb begin
    if (in_beat_i.field_width > FieldCap) begin
      width_sat = FieldCap;
    end else begin
      width_sat = in_beat_i.field_width;
    end
    nbytes = 3'd1 + 3'(in_beat_i.value[31:7] != '0) + 3'(in_beat_i.value[31:14] != '0)
           + 3'(in_beat_i.value[31:21] != '0) + 3'(in_beat_i.value[31:28] != '0);
    if (action_e'(in_beat_i.action) == ActWriteVarint) begin
      added = {nbytes, 3'b000};
    end else begin
      added = width_sat;
    end
    cnt_sum  = {1'b0, cnt_q} + (TotalW + 1)'(added);
    tot_bits = {4'b0000, pcnt_q} + {1'b0, added};
    fl_byte  = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));
  end

  always_comb begin
    if (rem_q >= 6'd8) begin
      k = 4'd8;
    end else begin
      k = rem_q[3:0];
    end
    more = (src_q[ValueW-1:SeptetBits] != '0);
    if (varint_q) begin
      digit = {more, src_q[6:0] & SeptetMask};
    end else begin
      digit = src_q[ValueW-1:ValueW-8];
    end
    acc     = ({8'b0, pend_q} << k) | 15'(digit >> (4'd8 - k));
    n_next  = {1'b0, pcnt_q} + k;
    emit    = n_next[3];
    run_end = (rem_q == {2'b00, k});
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    rem_d       = rem_q;
    left_d      = left_q;
    varint_d    = varint_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          unique case (action_e'(in_beat_i.action))
            ActClear: begin
              pend_d         = '0;
              pcnt_d         = '0;
              cnt_d          = '0;
              res_valid_o    = 1'b1;
              res_o.last     = 1'b1;
            end
            ActFlush: begin
              pend_d           = '0;
              pcnt_d           = '0;
              res_valid_o      = 1'b1;
              res_o.out_byte   = fl_byte;
              res_o.byte_valid = (pcnt_q != '0);
              res_o.last       = 1'b1;
              res_o.bits_total = cnt_q;
            end
            ActWriteBits, ActWriteVarint: begin
              if (added != '0) begin
                if (cnt_sum[TotalW]) begin
                  cnt_d = CounterMax;
                end else begin
                  cnt_d = cnt_sum[TotalW-1:0];
                end
                varint_d = (action_e'(in_beat_i.action) == ActWriteVarint);
                if (varint_d) begin
                  src_d = in_beat_i.value;
                end else begin
                  src_d = ValueW'(in_beat_i.value << (6'd32 - width_sat));
                end
                rem_d   = added;
                left_d  = tot_bits[5:3];
                state_d = StRun;
              end
            end
            default: ;
          endcase
        end
      end
      StRun: begin
        if (step) begin
          pcnt_d = n_next[2:0];
          pend_d = acc[6:0] & ~(7'h7F << n_next[2:0]);
          if (emit) begin
            res_valid_o      = 1'b1;
            res_o.out_byte   = 8'(acc >> n_next[2:0]);
            res_o.byte_valid = 1'b1;
            res_o.last       = (left_q == 3'd1);
            res_o.bits_total = cnt_q;
            left_d           = left_q - 3'd1;
          end
          if (varint_q) begin
            src_d = src_q >> SeptetBits;
          end else begin
            src_d = src_q << 8;
          end
          rem_d = rem_q - {2'b00, k};
          if (run_end) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= '0;
      pcnt_q  <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    varint_q <= varint_d;
  end

  a_run_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (rem_q != '0))
    else $error("running with no bits left");

  a_left_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != '0) |-> (state_q == StRun))
    else $error("bytes owed while idle");

  a_all_bytes_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && run_end) |-> (left_q == (emit ? 3'd1 : 3'd0)))
    else $error("byte count mismatch at end of field");

  a_res_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_rdy_i)
    else $error("result produced without room in output stage");

endmodule

`default_nettype wire

FILE: hw/rtl/mbp_out_stage.sv
// output register between the shifter and the result channel
`default_nettype none

module mbp_out_stage
  import mbp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  wire res_t res_i,
  output logic      out_rdy_o,
  output logic      out_valid_o,
  output res_t      out_res_o,
  input  wire logic out_ready_i
);

  logic ov_q, ov_d;
  res_t res_q;

  assign out_rdy_o   = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  always_comb begin
    if (res_valid_i) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_msb_first_bit_packer.sv
// testbench for msb_first_bit_packer: directed rows, random beats and idling phases
`default_nettype none

module tb_msb_first_bit_packer
  import mbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic typed;
    res_t want;
  } fixed_res_t;

  typedef struct packed {
    in_beat_t   beat;
    fixed_res_t fixed;
  } dir_row_t;

  localparam int NumDir = 24;
  localparam int HoldCycles = 250;

  logic clk;
  logic rst_n;

  mbp_in_if  in_if ();
  mbp_out_if out_if ();

  msb_first_bit_packer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dir_row_t dir_rows [NumDir] = '{
    '{'{ActFlush,       32'h0000_0000, 6'd0},  '{1'b1, '{8'h00, 1'b0, 1'b1, 20'd0}}},
    '{'{ActWriteBits,   32'hFFFF_FFFF, 6'd0},  '0},
    '{'{ActWriteBits,   32'h0000_00A5, 6'd8},  '{1'b1, '{8'hA5, 1'b1, 1'b1, 20'd8}}},
    '{'{ActWriteBits,   32'hFFFF_FFFF, 6'd63}, '0},
    '{'{ActWriteBits,   32'h0000_0000, 6'd32}, '0},
    '{'{ActWriteBits,   32'h0000_0005, 6'd3},  '0},
    '{'{ActFlush,       32'h0000_0000, 6'd0},  '{1'b1, '{8'hA0, 1'b1, 1'b1, 20'd75}}},
    '{'{ActWriteBits,   32'h0000_0001, 6'd1},  '0},
    '{'{ActWriteVarint, 32'h0000_0000, 6'd0},  '0},
    '{'{ActWriteVarint, 32'hFFFF_FFFF, 6'd63}, '0},
    '{'{ActWriteVarint, 32'h0000_007F, 6'd1},  '0},
    '{'{ActWriteVarint, 32'h0000_0080, 6'd32}, '0},
    '{'{ActWriteVarint, 32'h0000_3FFF, 6'd7},  '0},
    '{'{ActWriteBits,   32'h0000_007F, 6'd7},  '0},
    '{'{ActWriteBits,   32'h1234_5678, 6'd33}, '0},
    '{'{ActWriteBits,   32'h0000_0000, 6'd1},  '0},
    '{'{ActClear,       32'hFFFF_FFFF, 6'd63}, '{1'b1, '{8'h00, 1'b0, 1'b1, 20'd0}}},
    '{'{ActFlush,       32'hFFFF_FFFF, 6'd63}, '{1'b1, '{8'h00, 1'b0, 1'b1, 20'd0}}},
    '{'{ActWriteBits,   32'hFFFF_0000, 6'd16}, '0},
    '{'{ActWriteVarint, 32'h0FFF_FFFF, 6'd0},  '0},
    '{'{ActWriteVarint, 32'h1000_0000, 6'd0},  '0},
    '{'{ActWriteBits,   32'h0000_001F, 6'd5},  '0},
    '{'{ActClear,       32'h0000_0000, 6'd0},  '{1'b1, '{8'h00, 1'b0, 1'b1, 20'd0}}},
    '{'{ActWriteBits,   32'hFFFF_FFFF, 6'd32}, '0}
  };

  res_t             bytes_due [$];
  fixed_res_t       fixed_due [$];
  logic [6:0]       pend_bits;
  logic [2:0]       pend_cnt;
  logic [TotalW-1:0] bit_cnt;
  int               mismatches;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  bit               hold_req;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // expected bytes of one accepted beat (or the row's fixed result), pending bits and counter updated
  function automatic void pack_beat(input in_beat_t b, input fixed_res_t fx);
    logic [63:0]  acc;
    logic [31:0]  rest;
    logic [7:0]   septet;
    int unsigned  n;
    int unsigned  w;
    int unsigned  added;
    int unsigned  nbytes;
    res_t         r;
    res_t         made [$];
    acc = 64'(pend_bits);
    n = 32'(pend_cnt);
    added = 0;
    case (action_e'(b.action))
      ActClear: begin
        pend_bits = '0;
        pend_cnt = '0;
        bit_cnt = '0;
        r = '{8'h00, 1'b0, 1'b1, '0};
        made.insert(made.size(), r);
      end
      ActFlush: begin
        r.out_byte = (n > 0) ? 8'(acc << (8 - n)) : 8'h00;
        r.byte_valid = (n > 0);
        r.last = 1'b1;
        r.bits_total = bit_cnt;
        pend_bits = '0;
        pend_cnt = '0;
        made.insert(made.size(), r);
      end
      default: begin
        if (action_e'(b.action) == ActWriteBits) begin
          w = 32'(b.field_width);
          if (w > MaxFieldBits) w = MaxFieldBits;
          if (w > 32) w = 32;
          if (w > 0) begin
            acc = (acc << w) | (64'(b.value) & ((64'd1 << w) - 64'd1));
            n += w;
            added = w;
          end
        end else begin
          rest = b.value;
          do begin
            septet = {1'b0, rest[6:0]};
            rest = rest >> SeptetBits;
            if (rest != 0) septet[7] = 1'b1;
            acc = (acc << 8) | 64'(septet);
            n += 8;
            added += 8;
          end while (rest != 0);
        end
        if (32'(bit_cnt) + added > 32'(CounterMax)) bit_cnt = CounterMax;
        else bit_cnt = bit_cnt + TotalW'(added);
        nbytes = n / 8;
        for (int k = 0; k < nbytes; k++) begin
          r.out_byte = 8'(acc >> (n - 8 * (k + 1)));
          r.byte_valid = 1'b1;
          r.last = (k == nbytes - 1);
          r.bits_total = bit_cnt;
          made.insert(made.size(), r);
        end
        n = n % 8;
        pend_bits = 7'(acc & ((64'd1 << n) - 64'd1));
        pend_cnt = 3'(n);
      end
    endcase
    if (fx.typed) bytes_due.insert(bytes_due.size(), fx.want);
    else foreach (made[i]) bytes_due.insert(bytes_due.size(), made[i]);
  endfunction

  function automatic in_beat_t rand_beat();
    int unsigned pick;
    in_beat_t    b;
    pick = $urandom_range(99);
    b.value = $urandom;
    b.field_width = 6'($urandom_range(1, 32));
    if (pick < 45) begin
      b.action = ActWriteBits;
      if ($urandom_range(9) == 0) b.field_width = 6'($urandom_range(0, 63));
    end else if (pick < 80) begin
      b.action = ActWriteVarint;
      b.value = b.value >> $urandom_range(0, 31);
    end else if (pick < 93) begin
      b.action = ActFlush;
    end else begin
      b.action = ActClear;
    end
    return b;
  endfunction

  task automatic note_diff(input string fld, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %0h got %0h", $realtime, fld, want, got);
    mismatches++;
  endtask

  task automatic send_beat(input in_beat_t b, input fixed_res_t fx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    fixed_due.insert(fixed_due.size(), fx);
    in_if.valid       <= 1'b1;
    in_if.action      <= b.action;
    in_if.value       <= b.value;
    in_if.field_width <= b.field_width;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // accepted input beats feed the predictor, result beats are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        pack_beat('{in_if.action, in_if.value, in_if.field_width}, fixed_due.pop_front());
      if (out_if.valid && out_if.ready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected beat, got byte %0h valid %0b last %0b total %0h",
                   $realtime, out_if.out_byte, out_if.byte_valid, out_if.last,
                   out_if.bits_total);
          mismatches++;
        end else begin
          res_t want;
          want = bytes_due.pop_front();
          if (out_if.out_byte !== want.out_byte)
            note_diff("out_byte", 32'(want.out_byte), 32'(out_if.out_byte));
          if (out_if.byte_valid !== want.byte_valid)
            note_diff("byte_valid", 32'(want.byte_valid), 32'(out_if.byte_valid));
          if (out_if.last !== want.last)
            note_diff("last", 32'(want.last), 32'(out_if.last));
          if (out_if.bits_total !== want.bits_total)
            note_diff("bits_total", 32'(want.bits_total), 32'(out_if.bits_total));
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_left = HoldCycles;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.action      <= ActWriteBits;
    in_if.value       <= '0;
    in_if.field_width <= '0;
    pend_bits = '0;
    pend_cnt = '0;
    bit_cnt = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].fixed);

    // receiver holds off while beats keep coming
    hold_req = 1'b1;
    repeat (20) send_beat(rand_beat(), '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      repeat (65) send_beat(rand_beat(), '0);
    end

    // closing beats: odd widths, widest varint, flushes, a clear and a last 8-bit write
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_beat('{ActWriteBits, $urandom, 6'd31}, '0);
    send_beat('{ActWriteBits, $urandom, 6'd1}, '0);
    send_beat('{ActWriteBits, $urandom, 6'd13}, '0);
    send_beat('{ActWriteVarint, 32'hFFFF_FFFF, 6'd0}, '0);
    send_beat('{ActFlush, 32'h0, 6'd0}, '0);
    send_beat('{ActWriteBits, $urandom, 6'd9}, '0);
    send_beat('{ActFlush, 32'h0, 6'd0}, '0);
    send_beat('{ActClear, 32'h0, 6'd0}, '0);
    send_beat('{ActWriteBits, 32'h0000_00C3, 6'd8}, '0);
    in_if.valid <= 1'b0;

    while (bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: msb_first_bit_packer.f
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_in_if.sv
hw/rtl/mbp_out_if.sv
hw/rtl/mbp_digit_shifter.sv
hw/rtl/mbp_out_stage.sv
hw/rtl/msb_first_bit_packer.sv
sim/tb_msb_first_bit_packer.sv
